// ===== sv/bayer_roi_channel_average_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Bayer ROI channel average block
// Shared property wrappers on the block clock with reset masking.
// ----------------------------------------------------------------------------
`ifndef BAYER_ROI_CHANNEL_AVERAGE_TOP_MACROS_SVH
`define BAYER_ROI_CHANNEL_AVERAGE_TOP_MACROS_SVH

// Plain property checked on every rising edge outside reset.
`define BRA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define BRA_ASSERT_NEXT(label, ante, cons, msg) \
  `BRA_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== sv/bra_pkg.sv =====
// ----------------------------------------------------------------------------
// bra_pkg
// Types and constants shared by the Bayer ROI channel average block.
// ----------------------------------------------------------------------------
`default_nettype none

package bra_pkg;

  // Accumulator and output widths.
  localparam int SUM_W       = 32;
  localparam int CNT_W       = 23;
  localparam int STEP_W      = $clog2(SUM_W);
  localparam int OUT_W       = 10;
  localparam int OUT_MAX     = 1023;
  localparam int OUT_TDATA_W = 4 * OUT_W;

  // Configuration register widths.
  localparam int CFG_W       = 13;
  localparam int CFG_ADDR_W  = 3;
  localparam int FRAME_W_W   = 13;
  localparam int ROI_W       = 12;
  localparam int ORDER_W     = 2;
  localparam int BLACK_W     = 10;

  // Configuration reset values.
  localparam logic [FRAME_W_W-1:0] RST_FRAME_WIDTH = 13'd4096;
  localparam logic [ROI_W-1:0]     RST_ROI_LEFT    = 12'd0;
  localparam logic [ROI_W-1:0]     RST_ROI_TOP     = 12'd0;
  localparam logic [ROI_W-1:0]     RST_ROI_RIGHT   = 12'd4095;
  localparam logic [ROI_W-1:0]     RST_ROI_BOTTOM  = 12'd4095;
  localparam logic [ORDER_W-1:0]   RST_BAYER_ORDER = 2'd1;
  localparam logic [BLACK_W-1:0]   RST_BLACK_LEVEL = 10'd64;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FRAME_WIDTH = 3'd0,
    CFG_ROI_LEFT    = 3'd1,
    CFG_ROI_TOP     = 3'd2,
    CFG_ROI_RIGHT   = 3'd3,
    CFG_ROI_BOTTOM  = 3'd4,
    CFG_BAYER_ORDER = 3'd5,
    CFG_BLACK_LEVEL = 3'd6
  } cfg_idx_t;

  // Phase feeding each channel, per color order. Two bits per channel,
  // R in the lowest bits, then Gr, Gb and B.
  localparam logic [7:0] PHASE_MAP [4] = '{
    8'b00011011,
    8'b11100100,
    8'b01001110,
    8'b10110001
  };

  // Frame sequencer states.
  typedef enum logic [1:0] {
    ST_ACC,
    ST_START,
    ST_WAIT,
    ST_OUT
  } bra_state_t;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== sv/bra_div.sv =====
// ----------------------------------------------------------------------------
// bra_div
// Restoring radix-2 divider, one quotient bit per cycle, shared by all phases.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bra_pkg::SUM_W-1:0]   dividend,
  input  logic [bra_pkg::CNT_W-1:0]   divisor,
  output logic [bra_pkg::SUM_W-1:0]   quotient,
  output bra_pkg::div_stat_t          stat
);
  import bra_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;

  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  // One trial subtraction of the shifted partial remainder.
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  // Iteration control and datapath next values.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(SUM_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], fits};
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// ===== sv/bayer_roi_channel_average_top.sv =====
// Bayer ROI channel averages.
// Input stream: one raw pixel per beat in raster order (in_tdata, pixel in the
// low PIXEL_BITS bits); in_tlast marks the last pixel of a frame. Column and
// row are counted inside; pixels in the inclusive region are summed per 2x2
// phase relative to the region's top-left corner.
// While in_tready is high, ordinary pixels stream at one per clock.
// The frame's last pixel starts the frame result: the four phase sums pass
// one after another through a shared restoring divider of 32 steps, and the
// result is then loaded into the output register. in_tready is low from the
// taking of the last pixel until that load.
// Output stream: one beat per frame with the R, Gr, Gb and B averages, black
// level removed and clamped. The result sits in an output register; the next
// frame's pixels are taken while it waits, and a later frame result waits in
// the sequencer until the receiver has taken the earlier one.
// Reset (rst_n low, synchronous) clears counters, sums and the output beat and
// loads the default configuration. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
// bayer_roi_channel_average_top
// Region statistics over a raw Bayer stream with per-channel averaging.
// ----------------------------------------------------------------------------
`default_nettype none

module bayer_roi_channel_average_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int PIXEL_BITS = 10,
  localparam int IN_TDATA_W = ((PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_TDATA_W-1:0]            in_tdata,   // [PIXEL_BITS-1:0] pixel
  input  logic                             in_tlast,   // frame_end
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [9:0] red_avg, [19:10] green_red_avg, [29:20] green_blue_avg, [39:30] blue_avg
  output logic [bra_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // Configuration write port
  input  logic                             cfg_wr_en,
  input  logic [bra_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bra_pkg::CFG_W-1:0]        cfg_wdata
);
  import bra_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CCW = (CW > ROI_W) ? CW : ROI_W;
  localparam int RCW = (RW > ROI_W) ? RW : ROI_W;
  localparam int CIW = ((CW > FRAME_W_W) ? CW : FRAME_W_W) + 1;
  localparam int VW  = (PIXEL_BITS > OUT_W) ? PIXEL_BITS : OUT_W;
  localparam logic [SUM_W-1:0] PIX_MAX = SUM_W'((1 << PIXEL_BITS) - 1);

  // Configuration registers.
  logic [FRAME_W_W-1:0] frame_width_r;
  logic [ROI_W-1:0]     roi_left_r, roi_top_r, roi_right_r, roi_bottom_r;
  logic [ORDER_W-1:0]   bayer_order_r;
  logic [BLACK_W-1:0]   black_level_r;

  // Sequencer and accumulators.
  bra_state_t        state_r, state_nxt;
  logic [1:0]        ph_idx_r, ph_idx_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [SUM_W-1:0]  sums_r [4];
  logic [SUM_W-1:0]  sums_nxt [4];
  logic [CNT_W-1:0]  cnts_r [4];
  logic [CNT_W-1:0]  cnts_nxt [4];
  logic [OUT_W-1:0]  chan_r [4];
  logic [OUT_W-1:0]  chan_nxt [4];
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Sequencer outputs.
  logic              in_beat;
  logic              div_start;
  logic              capture;
  logic              load_out;

  // Pixel position.
  logic [PIXEL_BITS-1:0] pixel;
  logic              in_roi;
  logic [1:0]        ph_sel;
  logic [CIW-1:0]    col_inc;
  logic              col_wrap;
  logic [RW:0]       row_inc;

  // Divider and channel value.
  logic [SUM_W-1:0]  quotient;
  div_stat_t         div_stat;
  logic [CNT_W-1:0]  cur_cnt;
  logic [VW-1:0]     avg_v;
  logic [VW-1:0]     blk_v;
  logic [VW-1:0]     diff_v;
  logic [OUT_W-1:0]  ph_value;

  assign pixel   = in_tdata[PIXEL_BITS-1:0];
  assign in_beat = in_tvalid && in_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= RST_FRAME_WIDTH;
      roi_left_r    <= RST_ROI_LEFT;
      roi_top_r     <= RST_ROI_TOP;
      roi_right_r   <= RST_ROI_RIGHT;
      roi_bottom_r  <= RST_ROI_BOTTOM;
      bayer_order_r <= RST_BAYER_ORDER;
      black_level_r <= RST_BLACK_LEVEL;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_FRAME_WIDTH: frame_width_r <= cfg_wdata[FRAME_W_W-1:0];
        CFG_ROI_LEFT:    roi_left_r    <= cfg_wdata[ROI_W-1:0];
        CFG_ROI_TOP:     roi_top_r     <= cfg_wdata[ROI_W-1:0];
        CFG_ROI_RIGHT:   roi_right_r   <= cfg_wdata[ROI_W-1:0];
        CFG_ROI_BOTTOM:  roi_bottom_r  <= cfg_wdata[ROI_W-1:0];
        CFG_BAYER_ORDER: bayer_order_r <= cfg_wdata[ORDER_W-1:0];
        CFG_BLACK_LEVEL: black_level_r <= cfg_wdata[BLACK_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state of the frame sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACC:   if (in_beat && in_tlast) state_nxt = ST_START;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_stat.done) state_nxt = (ph_idx_r == 2'd3) ? ST_OUT : ST_START;
      end
      ST_OUT:   if (!out_tvalid_r || out_tready) state_nxt = ST_ACC;
      default:  state_nxt = ST_ACC;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    capture   = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_ACC:   in_tready = 1'b1;
      ST_START: div_start = 1'b1;
      ST_WAIT:  capture   = div_stat.done;
      ST_OUT:   load_out  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  // Phase selection: the region's top-left pixel is phase zero.
  always_comb begin
    in_roi = (CCW'(col_r) >= CCW'(roi_left_r)) && (CCW'(col_r) <= CCW'(roi_right_r)) &&
             (RCW'(row_r) >= RCW'(roi_top_r)) && (RCW'(row_r) <= RCW'(roi_bottom_r));
    ph_sel = {row_r[0] ^ roi_top_r[0], col_r[0] ^ roi_left_r[0]};
  end

  // Column and row counters; a frame's last pixel restarts them.
  always_comb begin
    col_inc  = CIW'(col_r) + CIW'(1);
    col_wrap = (col_inc >= CIW'(frame_width_r)) || (col_inc >= CIW'(MAX_WIDTH));
    row_inc  = (RW + 1)'(row_r) + (RW + 1)'(1);
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (in_beat) begin
      if (in_tlast) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_wrap) begin
        col_nxt = '0;
        row_nxt = (row_inc >= (RW + 1)'(MAX_HEIGHT)) ? '0 : row_inc[RW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  // Phase accumulator lanes, cleared once the frame result is handed over.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sums_nxt[i] = sums_r[i];
      cnts_nxt[i] = cnts_r[i];
      if (load_out) begin
        sums_nxt[i] = '0;
        cnts_nxt[i] = '0;
      end else if (in_beat && in_roi && (ph_sel == 2'(i))) begin
        sums_nxt[i] = sums_r[i] + SUM_W'(pixel);
        cnts_nxt[i] = cnts_r[i] + CNT_W'(1);
      end
    end
  end

  // Phase index walks the four phases through the divider.
  always_comb begin
    ph_idx_nxt = ph_idx_r;
    if (in_beat && in_tlast) ph_idx_nxt = 2'd0;
    else if (capture)        ph_idx_nxt = ph_idx_r + 2'd1;
  end

  assign cur_cnt = cnts_r[ph_idx_r];

  bra_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sums_r[ph_idx_r]),
    .divisor  (cur_cnt),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Average clamped to the pixel range, black level removed, clamped to output.
  always_comb begin
    avg_v  = (quotient > PIX_MAX) ? PIX_MAX[VW-1:0] : quotient[VW-1:0];
    blk_v  = VW'(black_level_r);
    diff_v = avg_v - blk_v;
    if (cur_cnt == '0 || avg_v <= blk_v) begin
      ph_value = '0;
    end else if (diff_v > VW'(OUT_MAX)) begin
      ph_value = OUT_W'(OUT_MAX);
    end else begin
      ph_value = diff_v[OUT_W-1:0];
    end
  end

  // Each channel slot takes the phase that the color order assigns to it.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      chan_nxt[k] = chan_r[k];
      if (capture && (PHASE_MAP[bayer_order_r][2*k +: 2] == ph_idx_r)) begin
        chan_nxt[k] = ph_value;
      end
    end
  end

  // Output register.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    if (out_tvalid_r && out_tready) out_tvalid_nxt = 1'b0;
    if (load_out) begin
      out_tvalid_nxt = 1'b1;
      out_data_nxt   = {chan_r[3], chan_r[2], chan_r[1], chan_r[0]};
    end
  end

  // Control and accumulator registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_ACC;
      ph_idx_r     <= 2'd0;
      col_r        <= '0;
      row_r        <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        sums_r[i] <= '0;
        cnts_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      ph_idx_r     <= ph_idx_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      for (int i = 0; i < 4; i++) begin
        sums_r[i] <= sums_nxt[i];
        cnts_r[i] <= cnts_nxt[i];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    for (int k = 0; k < 4; k++) begin
      chan_r[k] <= chan_nxt[k];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/bra_checker.sv =====
// ----------------------------------------------------------------------------
// bra_checker
// Port-level checks on the Bayer ROI channel average block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bayer_roi_channel_average_top_macros.svh"

module bra_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic                            in_tlast,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bra_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result beat stays offered and unchanged.
  `BRA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result beat dropped")
  `BRA_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed")

  // The last pixel of a frame starts the division pass, which blocks input.
  `BRA_ASSERT_NEXT(a_busy_after_last, in_tvalid && in_tready && in_tlast, !in_tready, "input taken during division")

  // Ordinary pixels stream without a gap.
  `BRA_ASSERT_NEXT(a_stream_pixels, in_tvalid && in_tready && !in_tlast, in_tready, "pixel stream stalled")

  // A new result beat only comes at the end of a division pass.
  `BRA_ASSERT(a_result_after_pass, $rose(out_tvalid) |-> $past(!in_tready), "result without frame end")

endmodule

bind bayer_roi_channel_average_top bra_checker u_bra_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
